// File: sv/swwq_pkg.sv
// ----------------------------------------------------------------------------
// swwq_pkg
// shared types and codes for the semaphore with wait queue
// ----------------------------------------------------------------------------
`default_nettype none

package swwq_pkg;

    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned ID_PORT_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

    typedef enum logic [2:0] {
        ST_ACQUIRED      = 3'd0,
        ST_ALREADY_OWNER = 3'd1,
        ST_BLOCKED       = 3'd2,
        ST_QUEUE_FULL    = 3'd3,
        ST_RELEASED      = 3'd4,
        ST_HANDED        = 3'd5,
        ST_NOT_OWNER     = 3'd6
    } status_t;

    typedef enum logic {
        KIND_DOWN = 1'b0,
        KIND_UP   = 1'b1
    } kind_t;

endpackage

`default_nettype wire

// File: sv/semaphore_with_wait_queue.sv
// ----------------------------------------------------------------------------
// semaphore_with_wait_queue
// counting semaphore with one owner and a fifo of waiting task ids
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload
//  -------   -----------------   -----------------------------------------------
//  request   start & !busy       kind, task_id
//  result    done (one cycle)    status, woken_valid, woken_task, owner_valid,
//                                owner_task, available
//  config    cfg_we              cfg_wdata (initial_count, also loads the count)
//
//  one item per cycle; each result appears on the cycle after its item
//  is accepted, set by the single state update and the result register
//  busy is held low: the wait queue ram is read ahead at the next head
//  address, so the oldest waiter is always ready at the next edge
//  reset clears count to 1, ownership and the queue pointers; the queue
//  ram needs no clearing since an entry is only read after it was written
//  the receiver cannot stall, results are shown for exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module semaphore_with_wait_queue #(
    parameter int unsigned QUEUE_DEPTH   = 16,
    parameter int unsigned TASK_ID_WIDTH = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request channel
    input  wire logic       start,
    output logic            busy,
    input  wire logic       kind,
    input  wire logic [7:0] task_id,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    // result channel
    output logic            done,
    output logic [2:0]      status,
    output logic            woken_valid,
    output logic [7:0]      woken_task,
    output logic            owner_valid,
    output logic [7:0]      owner_task,
    output logic [7:0]      available
);

    // only the low id bits that fit the 8-bit port take part
    localparam int unsigned ID_W   = (TASK_ID_WIDTH < swwq_pkg::ID_PORT_W) ?
                                     TASK_ID_WIDTH : swwq_pkg::ID_PORT_W;
    localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned USED_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [USED_W-1:0] USED_FULL = USED_W'(QUEUE_DEPTH);

    // semaphore state
    logic [7:0]        count_reg,  count_next;
    logic              own_reg,    own_next;
    logic [ID_W-1:0]   owner_reg,  owner_next;
    logic [PTR_W-1:0]  head_reg,   head_next;
    logic [PTR_W-1:0]  tail_reg,   tail_next;
    logic [USED_W-1:0] used_reg,   used_next;

    // read-ahead bypass for the head entry
    logic              byp_sel_reg;
    logic [ID_W-1:0]   byp_data_reg;
    logic [ID_W-1:0]   ram_rdata;
    logic [ID_W-1:0]   head_entry;

    // result register
    logic              done_reg;
    swwq_pkg::status_t status_reg, status_next;
    logic              woken_valid_reg, woken_valid_next;
    logic [ID_W-1:0]   woken_task_reg,  woken_task_next;

    logic              accept;
    logic              push;
    logic [ID_W-1:0]   req_id;

    assign accept = start & ~busy;
    assign req_id = task_id[ID_W-1:0];

    // oldest waiter: last cycle's push when it landed on the read address
    assign head_entry = byp_sel_reg ? byp_data_reg : ram_rdata;

    // ------------------------------------------------------------------
    // one request, one pass
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next       = count_reg;
        own_next         = own_reg;
        owner_next       = owner_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        used_next        = used_reg;
        push             = 1'b0;
        status_next      = status_reg;
        woken_valid_next = 1'b0;
        woken_task_next  = '0;

        if (accept)
        begin
            if (swwq_pkg::kind_t'(kind) == swwq_pkg::KIND_DOWN)
            begin
                if (own_reg && owner_reg == req_id)
                begin
                    status_next = swwq_pkg::ST_ALREADY_OWNER;
                end
                else if (count_reg != '0)
                begin
                    // granted, also when another task is recorded as owner
                    count_next  = count_reg - 8'd1;
                    own_next    = 1'b1;
                    owner_next  = req_id;
                    status_next = swwq_pkg::ST_ACQUIRED;
                end
                else if (used_reg == USED_FULL)
                begin
                    status_next = swwq_pkg::ST_QUEUE_FULL;
                end
                else
                begin
                    push        = 1'b1;
                    tail_next   = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                    used_next   = used_reg + 1'b1;
                    status_next = swwq_pkg::ST_BLOCKED;
                end
            end
            else
            begin
                if (!own_reg || owner_reg != req_id)
                begin
                    status_next = swwq_pkg::ST_NOT_OWNER;
                end
                else if (used_reg == '0)
                begin
                    // release, count saturates at its top
                    if (count_reg != swwq_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                    own_next    = 1'b0;
                    owner_next  = '0;
                    status_next = swwq_pkg::ST_RELEASED;
                end
                else
                begin
                    // hand ownership to the oldest waiter
                    head_next        = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                    used_next        = used_reg - 1'b1;
                    own_next         = 1'b1;
                    owner_next       = head_entry;
                    woken_valid_next = 1'b1;
                    woken_task_next  = head_entry;
                    status_next      = swwq_pkg::ST_HANDED;
                end
            end
        end

        // loading initial_count reloads the count
        if (cfg_we)
        begin
            count_next = cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // wait queue storage, read ahead at the next head
    // ------------------------------------------------------------------
    swwq_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH),
        .ADDR_W(PTR_W)
    ) u_queue_ram (
        .clk  (clk),
        .we   (push),
        .waddr(tail_reg),
        .wdata(req_id),
        .raddr(head_next),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= swwq_pkg::COUNT_RESET;
            own_reg     <= 1'b0;
            owner_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            used_reg    <= '0;
            byp_sel_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            own_reg     <= own_next;
            owner_reg   <= owner_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            used_reg    <= used_next;
            // ram read at the address being written returns stale data
            byp_sel_reg <= push && (tail_reg == head_next);
            done_reg    <= accept;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        byp_data_reg    <= req_id;
        status_reg      <= status_next;
        woken_valid_reg <= woken_valid_next;
        woken_task_reg  <= woken_task_next;
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign busy        = 1'b0;
    assign done        = done_reg;
    assign status      = status_reg;
    assign woken_valid = woken_valid_reg;
    assign woken_task  = 8'(woken_task_reg);
    // owner and count after the step are the live state registers
    assign owner_valid = own_reg;
    assign owner_task  = own_reg ? 8'(owner_reg) : 8'd0;
    assign available   = count_reg;

endmodule

`default_nettype wire

// File: sv/swwq_ram.sv
// ----------------------------------------------------------------------------
// swwq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module swwq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
